// ----- rtl/aes_ctr_cbcmac_ccm_engine_core_macros.svh -----
// Assertion helpers used by the engine controller
`ifndef AES_CTR_CBCMAC_CCM_ENGINE_CORE_MACROS_SVH
`define AES_CTR_CBCMAC_CCM_ENGINE_CORE_MACROS_SVH

// Implication checked on every rising clock edge outside reset
`define ACC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset
`define ACC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/acc_pkg.sv -----
package acc_pkg;

    localparam logic [1:0] MODE_CTR = 2'd0;
    localparam logic [1:0] MODE_CBC = 2'd1;
    localparam logic [1:0] MODE_CCM = 2'd2;

    localparam logic [2:0] CFG_KEY_HI = 3'd0;
    localparam logic [2:0] CFG_KEY_LO = 3'd1;
    localparam logic [2:0] CFG_CTR_HI = 3'd2;
    localparam logic [2:0] CFG_CTR_LO = 3'd3;
    localparam logic [2:0] CFG_MAC_HI = 3'd4;
    localparam logic [2:0] CFG_MAC_LO = 3'd5;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_NOSUP = 1'b1;

    localparam logic [3:0] LAST_ROUND = 4'd10;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CTR_RUN,
        S_CTR_DONE,
        S_MAC_RUN,
        S_MAC_DONE,
        S_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic take;       // latch item, apply restart
        logic ctr_load;   // load AES state from counter
        logic mac_load;   // load AES state from mac xor data
        logic round;      // run one round
        logic ctr_store;  // store keystream xor data, bump counter
        logic mac_store;  // store new mac
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic last;       // current round is the final one
    } t_stat;

    typedef logic [7:0] t_sbox [256];
    localparam t_sbox SBOX = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] a);
        xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

endpackage

// ----- rtl/acc_if.sv -----
interface acc_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic        decrypt;
    logic        restart;
    logic [63:0] data_high;
    logic [63:0] data_low;
    modport source (output valid, mode, decrypt, restart, data_high, data_low, input ready);
    modport sink   (input valid, mode, decrypt, restart, data_high, data_low, output ready);
endinterface

interface acc_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] ctr_out_high;
    logic [63:0] ctr_out_low;
    logic [63:0] mac_high;
    logic [63:0] mac_low;
    logic        status;
    modport source (output valid, ctr_out_high, ctr_out_low, mac_high, mac_low, status,
                    input ready);
    modport sink   (input valid, ctr_out_high, ctr_out_low, mac_high, mac_low, status,
                    output ready);
endinterface

// ----- rtl/acc_datapath.sv -----
module acc_datapath
    import acc_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_cmd         i_cmd,
    output t_stat        o_stat,
    input  logic         i_restart,
    input  logic [127:0] i_data,
    input  logic [127:0] i_key,
    input  logic [127:0] i_ctr_start,
    input  logic [127:0] i_mac_start,
    output logic [127:0] o_ctr_res,
    output logic [127:0] o_mac
);

    logic [127:0] r_ctr, r_mac, r_res, r_data, r_st, r_rk;
    logic [3:0]   r_rnd;
    logic [7:0]   r_rcon;
    logic [127:0] n_st, n_rk, sub, mixed;
    logic [127:0] ctr_cur, mac_cur;
    logic [31:0]  tw;

    // restart values are registered when the item is taken, ahead of the first load
    assign ctr_cur = r_ctr;
    assign mac_cur = r_mac;

    // next round key (byte 0 is bits 127:120)
    always_comb begin
        tw = {SBOX[r_rk[23:16]] ^ r_rcon, SBOX[r_rk[15:8]], SBOX[r_rk[7:0]],
              SBOX[r_rk[31:24]]};
        n_rk[127:96] = r_rk[127:96] ^ tw;
        n_rk[95:64]  = r_rk[95:64] ^ n_rk[127:96];
        n_rk[63:32]  = r_rk[63:32] ^ n_rk[95:64];
        n_rk[31:0]   = r_rk[31:0] ^ n_rk[63:32];
    end

    // one AES round: sub bytes, shift rows, mix columns unless last, add round key
    always_comb begin
        logic [7:0] a0, a1, a2, a3, al;
        for (int c = 0; c < 4; c++) begin
            for (int j = 0; j < 4; j++) begin
                sub[127 - 8*(j + 4*c) -: 8] = SBOX[r_st[127 - 8*(j + 4*((c + j) & 3)) -: 8]];
            end
        end
        for (int c = 0; c < 4; c++) begin
            a0 = sub[127 - 32*c -: 8];
            a1 = sub[119 - 32*c -: 8];
            a2 = sub[111 - 32*c -: 8];
            a3 = sub[103 - 32*c -: 8];
            al = a0 ^ a1 ^ a2 ^ a3;
            mixed[127 - 32*c -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
            mixed[119 - 32*c -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
            mixed[111 - 32*c -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
            mixed[103 - 32*c -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
        end
        n_st = ((r_rnd == LAST_ROUND) ? sub : mixed) ^ n_rk;
    end

    assign o_stat.last = (r_rnd == LAST_ROUND);

    // hold state; load, round, store under controller command
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctr <= '0;
            r_mac <= '0;
            r_res <= '0;
        end else begin
            if (i_cmd.take && i_restart) begin
                r_ctr <= i_ctr_start;
                r_mac <= i_mac_start;
            end
            if (i_cmd.ctr_store) begin
                r_res <= r_st ^ r_data;
                r_ctr <= r_ctr + 128'd1;
            end
            if (i_cmd.mac_store) r_mac <= r_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) r_data <= i_data;
        if (i_cmd.ctr_load || i_cmd.mac_load) begin
            r_st   <= (i_cmd.ctr_load ? ctr_cur : (mac_cur ^ r_data)) ^ i_key;
            r_rk   <= i_key;
            r_rnd  <= 4'd1;
            r_rcon <= 8'h01;
        end else if (i_cmd.round) begin
            r_st   <= n_st;
            r_rk   <= n_rk;
            r_rnd  <= r_rnd + 4'd1;
            r_rcon <= xtime(r_rcon);
        end
    end

    assign o_ctr_res = r_res;
    assign o_mac     = r_mac;

endmodule

// ----- rtl/acc_ctrl.sv -----
`include "aes_ctr_cbcmac_ccm_engine_core_macros.svh"
module acc_ctrl
    import acc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_mode,
    input  logic       i_decrypt,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_status,
    output t_cmd       o_cmd,
    input  t_stat      i_stat
);

    t_state r_state, n_state;
    logic   r_ctr_en, r_mac_en, r_status;
    logic   take, dc, dm, nosup;
    t_cmd   cmd_base;

    assign take  = (r_state == S_IDLE) && i_in_valid;
    assign nosup = (i_mode == MODE_CBC) && i_decrypt;
    assign dc    = !nosup && (i_mode == MODE_CTR || i_mode == MODE_CCM);
    assign dm    = !nosup && (i_mode == MODE_CBC || i_mode == MODE_CCM);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = dc ? S_CTR_RUN : (dm ? S_MAC_RUN : S_OUT);
            end
            S_CTR_RUN:  if (i_stat.last) n_state = S_CTR_DONE;
            S_CTR_DONE: n_state = r_mac_en ? S_MAC_RUN : S_OUT;
            S_MAC_RUN:  if (i_stat.last) n_state = S_MAC_DONE;
            S_MAC_DONE: n_state = S_OUT;
            S_OUT:      if (i_out_ready) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // commands: loads happen on entry to a run state
    always_comb begin
        cmd_base = '0;
        case (r_state)
            S_IDLE: begin
                cmd_base.take = take;
            end
            S_CTR_RUN:  cmd_base.round = 1'b1;
            S_CTR_DONE: cmd_base.ctr_store = 1'b1;
            S_MAC_RUN:  cmd_base.round = 1'b1;
            S_MAC_DONE: cmd_base.mac_store = 1'b1;
            default: ;
        endcase
    end

    // register the loads (after take, or after the CTR store) so restart and stores settle
    logic r_ld_ctr, r_ld_mac;
    always_comb begin
        o_cmd = cmd_base;
        o_cmd.ctr_load = r_ld_ctr;
        o_cmd.mac_load = r_ld_mac;
        o_cmd.round = cmd_base.round && !r_ld_ctr && !r_ld_mac;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ld_ctr <= 1'b0;
            r_ld_mac <= 1'b0;
            r_ctr_en <= 1'b0;
            r_mac_en <= 1'b0;
            r_status <= STATUS_OK;
        end else begin
            r_state  <= n_state;
            r_ld_ctr <= take && dc;
            r_ld_mac <= (take && dm && !dc) || (r_state == S_CTR_DONE && r_mac_en);
            if (take) begin
                r_ctr_en <= dc;
                r_mac_en <= dm;
                r_status <= nosup ? STATUS_NOSUP : STATUS_OK;
            end
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_status    = r_status;

    `ACC_ASSERT_NEXT(a_take_leaves_idle, i_clk, i_rst_n, take, r_state != S_IDLE)
    `ACC_ASSERT_IMPL(a_one_load, i_clk, i_rst_n, 1'b1, !(r_ld_ctr && r_ld_mac))
    `ACC_ASSERT_IMPL(a_ctr_only_en, i_clk, i_rst_n, r_state == S_CTR_DONE, r_ctr_en)

endmodule

// ----- rtl/aes_ctr_cbcmac_ccm_engine_core.sv -----
// AES-128 CTR / CBC-MAC / CCM engine. One 128-bit block per item; the key, the
// counter start and the MAC start must be written through the register port
// while idle; the block itself does not enforce this. A single AES round unit
// with on-the-fly key expansion runs each encryption as a load, the rounds and
// a store, CCM running CTR and then CBC-MAC. A new item is accepted only once
// the output is taken, so a stalled output holds the engine. CBC with decrypt
// reports not supported and runs no encryption; restart reloads counter and MAC.
module aes_ctr_cbcmac_ccm_engine_core
    import acc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    acc_in_if.sink      s_in,
    acc_out_if.source   m_out
);

    logic [63:0] r_key_hi, r_key_lo, r_cs_hi, r_cs_lo, r_ms_hi, r_ms_lo;
    t_cmd         cmd;
    t_stat        stat;
    logic [127:0] ctr_res, mac;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_hi <= '0; r_key_lo <= '0;
            r_cs_hi  <= '0; r_cs_lo  <= '0;
            r_ms_hi  <= '0; r_ms_lo  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_KEY_HI: r_key_hi <= i_cfg_data;
                CFG_KEY_LO: r_key_lo <= i_cfg_data;
                CFG_CTR_HI: r_cs_hi  <= i_cfg_data;
                CFG_CTR_LO: r_cs_lo  <= i_cfg_data;
                CFG_MAC_HI: r_ms_hi  <= i_cfg_data;
                CFG_MAC_LO: r_ms_lo  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    acc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_in.valid),
        .o_in_ready  (s_in.ready),
        .i_mode      (s_in.mode),
        .i_decrypt   (s_in.decrypt),
        .o_out_valid (m_out.valid),
        .i_out_ready (m_out.ready),
        .o_status    (m_out.status),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    acc_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_restart   (s_in.restart),
        .i_data      ({s_in.data_high, s_in.data_low}),
        .i_key       ({r_key_hi, r_key_lo}),
        .i_ctr_start ({r_cs_hi, r_cs_lo}),
        .i_mac_start ({r_ms_hi, r_ms_lo}),
        .o_ctr_res   (ctr_res),
        .o_mac       (mac)
    );

    assign m_out.ctr_out_high = ctr_res[127:64];
    assign m_out.ctr_out_low  = ctr_res[63:0];
    assign m_out.mac_high     = mac[127:64];
    assign m_out.mac_low      = mac[63:0];

endmodule
